@@ hw/rtl/msg_pkg.sv @@
// Package for the maximal structure generation block.
// Command codes and configuration register indexes; no dependencies.
package msg_pkg;

  localparam logic CMD_DEFINE = 1'b0;
  localparam logic CMD_RUN    = 1'b1;

  localparam int REG_IDX_W = 2;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_RAW        = 2'd0;
  localparam reg_idx_t REG_PRODUCT    = 2'd1;
  localparam reg_idx_t REG_CONSIDERED = 2'd2;
  localparam reg_idx_t REG_EXCLUDED   = 2'd3;

  localparam int FIELD_W = 64;
  localparam int INDEX_W = 6;

endpackage

@@ hw/rtl/maximal_structure_generation.sv @@
// Top level of the maximal structure generation block.
// Uses msg_pkg, msg_table and msg_engine.
//
// channel   direction  ports                                         handshake
// command   in         command unit_index unit_input_mask             start & !busy
//                      unit_output_mask
// result    out        solution_found structure_units                 done strobe
//                      structure_materials
// config    in         wr_en reg_index wr_data                        wr_en
//
// A define word leaves busy low, so the next word can follow.
// A run walks the unit table once per pass:
// one pass for the initial reduction, one per removed material and one per
// needed material in composition (each bounded by NUM_MATERIALS + 1).
// busy is high for the whole run.
// Reset is synchronous; the table contents are undefined until defined.
// The result word is flagged by done, high for one cycle; the receiver cannot stall.
module maximal_structure_generation #(
  parameter int NUM_UNITS     = 64,
  parameter int NUM_MATERIALS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               command,
  input  logic [msg_pkg::INDEX_W-1:0]        unit_index,
  input  logic [msg_pkg::FIELD_W-1:0]        unit_input_mask,
  input  logic [msg_pkg::FIELD_W-1:0]        unit_output_mask,
  input  logic                               wr_en,
  input  logic [msg_pkg::REG_IDX_W-1:0]      reg_index,
  input  logic [msg_pkg::FIELD_W-1:0]        wr_data,
  output logic                               done,
  output logic                               solution_found,
  output logic [msg_pkg::FIELD_W-1:0]        structure_units,
  output logic [msg_pkg::FIELD_W-1:0]        structure_materials
);

  localparam int UA = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

  // configuration registers, trimmed to the real unit and material counts
  logic [NUM_MATERIALS-1:0] raw_mask;
  logic [NUM_MATERIALS-1:0] prod_mask;
  logic [NUM_UNITS-1:0]     considered;
  logic [NUM_UNITS-1:0]     excluded;
  logic [NUM_UNITS-1:0]     defined;

  logic                       accept;
  logic                       def_we;
  logic                       run;
  logic [2*NUM_MATERIALS-1:0] def_word;
  logic                       tbl_rd_en;
  logic [UA-1:0]              tbl_rd_addr;
  logic [2*NUM_MATERIALS-1:0] tbl_rd_data;
  logic [NUM_UNITS-1:0]       eng_units;
  logic [NUM_MATERIALS-1:0]   eng_mats;

  assign accept = start && !busy;
  // indexes past the table are dropped
  assign def_we = accept && (command == msg_pkg::CMD_DEFINE) &&
                  ({1'b0, unit_index} < 7'(NUM_UNITS));
  assign run    = accept && (command == msg_pkg::CMD_RUN);
  assign def_word = {unit_input_mask[NUM_MATERIALS-1:0],
                     unit_output_mask[NUM_MATERIALS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mask   <= '0;
      prod_mask  <= '0;
      considered <= '1;
      excluded   <= '0;
    end else if (wr_en) begin
      unique case (reg_index)
        msg_pkg::REG_RAW:        raw_mask   <= wr_data[NUM_MATERIALS-1:0];
        msg_pkg::REG_PRODUCT:    prod_mask  <= wr_data[NUM_MATERIALS-1:0];
        msg_pkg::REG_CONSIDERED: considered <= wr_data[NUM_UNITS-1:0];
        default:                 excluded   <= wr_data[NUM_UNITS-1:0];
      endcase
    end
  end

  // defined bits live in flops; the table itself is never cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      defined <= '0;
    end else if (def_we) begin
      defined[unit_index[UA-1:0]] <= 1'b1;
    end
  end

  msg_table #(
    .NUM_UNITS(NUM_UNITS), .NUM_MATERIALS(NUM_MATERIALS), .UA(UA)
  ) u_table (
    .clk     (clk),
    .wr_en   (def_we),
    .wr_addr (unit_index[UA-1:0]),
    .wr_data (def_word),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  msg_engine #(
    .NUM_UNITS(NUM_UNITS), .NUM_MATERIALS(NUM_MATERIALS), .UA(UA)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .base      (defined & considered & ~excluded),
    .raw       (raw_mask),
    .prod      (prod_mask),
    .rd_en     (tbl_rd_en),
    .rd_addr   (tbl_rd_addr),
    .rd_data   (tbl_rd_data),
    .busy      (busy),
    .done      (done),
    .found     (solution_found),
    .units_out (eng_units),
    .mats_out  (eng_mats)
  );

  assign structure_units     = msg_pkg::FIELD_W'(eng_units);
  assign structure_materials = msg_pkg::FIELD_W'(eng_mats);

endmodule

@@ hw/rtl/msg_table.sv @@
// Operating unit table: one word per unit, {consumes, produces}.
// Single write port, single read port with registered read data.
module msg_table #(
  parameter int NUM_UNITS     = 64,
  parameter int NUM_MATERIALS = 64,
  parameter int UA            = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [UA-1:0]              wr_addr,
  input  logic [2*NUM_MATERIALS-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [UA-1:0]              rd_addr,
  output logic [2*NUM_MATERIALS-1:0] rd_data
);

  logic [2*NUM_MATERIALS-1:0] mem [NUM_UNITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/msg_engine.sv @@
// Run sequencer: walks the unit table once per pass for reduction and
// composition. Depends on msg_table read timing (registered read data).
module msg_engine #(
  parameter int NUM_UNITS     = 64,
  parameter int NUM_MATERIALS = 64,
  parameter int UA            = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       run,
  input  logic [NUM_UNITS-1:0]       base,
  input  logic [NUM_MATERIALS-1:0]   raw,
  input  logic [NUM_MATERIALS-1:0]   prod,
  output logic                       rd_en,
  output logic [UA-1:0]              rd_addr,
  input  logic [2*NUM_MATERIALS-1:0] rd_data,
  output logic                       busy,
  output logic                       done,
  output logic                       found,
  output logic [NUM_UNITS-1:0]       units_out,
  output logic [NUM_MATERIALS-1:0]   mats_out
);

  localparam int NM = NUM_MATERIALS;
  localparam int NU = NUM_UNITS;
  localparam int IW = $clog2(NM + 2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_NEXT = 2'd3;

  localparam logic [1:0] PH_INIT = 2'd0;
  localparam logic [1:0] PH_RED  = 2'd1;
  localparam logic [1:0] PH_COMP = 2'd2;

  logic [1:0]    state;
  logic [1:0]    phase;
  logic          iss;
  logic [UA-1:0] addr;
  logic          rd_vld;
  logic [UA-1:0] rd_idx;
  logic [IW-1:0] it;
  logic          fail;

  logic [NU-1:0] base_r;
  logic [NU-1:0] units;
  logic [NU-1:0] chosen;
  logic [NM-1:0] acc_c, acc_p, acc_rp;
  logic [NM-1:0] nonprod, need, incl, covered, sel;

  logic [NM-1:0] c_u, p_u, mats, fresh, vec, low;
  logic          rem, keep, add, last_data;

  assign c_u   = rd_data[2*NM-1:NM];
  assign p_u   = rd_data[NM-1:0];
  assign mats  = acc_c | acc_p;
  assign fresh = (acc_c & ~acc_p) & acc_rp & ~raw;
  assign vec   = (phase == PH_COMP) ? need : nonprod;
  assign low   = vec & (~vec + 1'b1);

  // removal is against the whole run pool, not just the surviving units
  assign rem  = base_r[rd_idx] && ((c_u & sel) != '0);
  assign keep = units[rd_idx] && !rem;
  assign add  = units[rd_idx] && ((p_u & sel) != '0);
  assign last_data = rd_vld && (rd_idx == UA'(NU - 1));

  assign busy    = (state != S_IDLE);
  assign rd_en   = (state == S_SCAN) && iss;
  assign rd_addr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      phase  <= PH_INIT;
      iss    <= 1'b0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (run) begin
            base_r <= base;
            units  <= '0;
            it     <= '0;
            phase  <= PH_INIT;
            sel    <= '0;
            iss    <= 1'b1;
            addr   <= '0;
            acc_c  <= '0;
            acc_p  <= '0;
            acc_rp <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (iss) begin
            addr <= addr + 1'b1;
            if (addr == UA'(NU - 1)) begin
              iss <= 1'b0;
            end
          end
          rd_vld <= iss;
          rd_idx <= addr;
          if (rd_vld) begin
            unique case (phase)
              PH_INIT: begin
                if (base_r[rd_idx]) begin
                  if ((p_u & raw) == '0) begin
                    units[rd_idx] <= 1'b1;
                    acc_c <= acc_c | c_u;
                    acc_p <= acc_p | p_u;
                  end
                end
              end
              PH_RED: begin
                if (rem) begin
                  units[rd_idx] <= 1'b0;
                  acc_rp <= acc_rp | p_u;
                end
                if (keep) begin
                  acc_c <= acc_c | c_u;
                  acc_p <= acc_p | p_u;
                end
              end
              default: begin
                if (add) begin
                  chosen[rd_idx] <= 1'b1;
                  acc_c   <= acc_c | c_u;
                  covered <= covered | c_u | p_u;
                end
              end
            endcase
          end
          if (last_data) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          unique case (phase)
            PH_INIT: begin
              nonprod <= mats & ~raw & ~acc_p;
              fail    <= (prod & ~mats) != '0;
            end
            PH_RED: begin
              nonprod <= (nonprod & mats) | fresh;
              fail    <= (prod & ~mats) != '0;
              it      <= it + 1'b1;
            end
            default: begin
              need <= (need | acc_c) & ~(raw | incl);
              it   <= it + 1'b1;
            end
          endcase
          state <= S_NEXT;
        end
        default: begin
          acc_c  <= '0;
          acc_p  <= '0;
          acc_rp <= '0;
          addr   <= '0;
          if (phase != PH_COMP) begin
            priority if (fail) begin
              done      <= 1'b1;
              found     <= 1'b0;
              units_out <= '0;
              mats_out  <= '0;
              state     <= S_IDLE;
            end else if ((nonprod != '0) && (it <= IW'(NM))) begin
              sel   <= low;
              phase <= PH_RED;
              iss   <= 1'b1;
              state <= S_SCAN;
            end else begin
              // composition starts from the products
              need    <= prod;
              incl    <= '0;
              chosen  <= '0;
              covered <= '0;
              it      <= '0;
              phase   <= PH_COMP;
            end
          end else begin
            if ((need != '0) && (it <= IW'(NM))) begin
              sel   <= low;
              incl  <= incl | low;
              iss   <= 1'b1;
              state <= S_SCAN;
            end else begin
              done      <= 1'b1;
              found     <= 1'b1;
              units_out <= chosen;
              mats_out  <= covered;
              state     <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/msg_checker.sv @@
// Port-level checks for maximal_structure_generation.
// Bound onto the top level; uses msg_pkg command codes.
module msg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          command,
  input logic                          done,
  input logic                          solution_found,
  input logic [msg_pkg::FIELD_W-1:0]   structure_units,
  input logic [msg_pkg::FIELD_W-1:0]   structure_materials
);

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command == msg_pkg::CMD_RUN) |=> busy)
    else $error("run word not followed by busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result word outside a run");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result word repeated");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !solution_found |-> (structure_units == '0) && (structure_materials == '0))
    else $error("no-solution word carries a structure");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("not idle after reset");

endmodule

bind maximal_structure_generation msg_checker u_msg_checker (
  .clk                 (clk),
  .rst                 (rst),
  .start               (start),
  .busy                (busy),
  .command             (command),
  .done                (done),
  .solution_found      (solution_found),
  .structure_units     (structure_units),
  .structure_materials (structure_materials)
);
